>>> sv/es2u_pkg.sv
// ----------------------------------------------------------------------------
// es2u_pkg: shared constants and types for the epoch-to-UTC converter
// Reciprocal constants for the constant divisions, the month base table
// and the calendar result bundle.
// ----------------------------------------------------------------------------
package es2u_pkg;

	// Time constants
	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;

	// Calendar constants
	localparam int JAN_FEB_DAYS  = 31 + 28;
	localparam int DAYS_TO_EPOCH = 719527;
	localparam int DAYS_PER_400Y = 365 * 400 + 100 - 4 + 1;
	localparam int MAR_BASE_DAY  = 306;
	localparam int YEAR_OFFSET   = 2;

	// Request-to-result latency in cycles
	localparam int LATENCY = 8;

	// days = (secs >> 7) / 675, since 86400 = 128 * 675
	localparam int DAY_PRESHIFT = 7;
	localparam int DAY_DIV      = SECS_PER_DAY >> DAY_PRESHIFT;
	localparam int DAY_SHIFT    = 35;
	localparam logic [25:0] DAY_RECIP =
		26'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

	localparam int HOUR_SHIFT = 29;
	localparam logic [17:0] HOUR_RECIP =
		18'(((64'd1 << HOUR_SHIFT) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));

	localparam int MIN_SHIFT = 18;
	localparam logic [12:0] MIN_RECIP =
		13'(((64'd1 << MIN_SHIFT) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

	localparam int WDAY_SHIFT = 19;
	localparam logic [16:0] WDAY_RECIP =
		17'(((64'd1 << WDAY_SHIFT) + 64'd6) / 64'd7);

	localparam int YEAR_SHIFT = 47;
	localparam logic [29:0] YEAR_RECIP =
		30'(((64'd1 << YEAR_SHIFT) + 64'(DAYS_PER_400Y) - 64'd1) / 64'(DAYS_PER_400Y));

	localparam int CENT_SHIFT = 19;
	localparam logic [12:0] CENT_RECIP =
		13'(((64'd1 << CENT_SHIFT) + 64'd99) / 64'd100);

	localparam int MON_SHIFT = 21;
	localparam logic [12:0] MON_RECIP =
		13'(((64'd1 << MON_SHIFT) + 64'(MAR_BASE_DAY) - 64'd1) / 64'(MAR_BASE_DAY));

	// Day 0 of the March-based count is March 1 of 1 BC
	localparam logic [19:0] DAYS_TO_MAR0 = 20'(DAYS_TO_EPOCH - JAN_FEB_DAYS);

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  mday;
		logic [2:0]  wday;
	} date_t;

	// 367 * m / 12 - 30: day of year (March based) where month m starts
	function automatic logic [8:0] month_base(input logic [3:0] m);
		logic [8:0] b;
		unique case (m)
			4'd1:    b = 9'd0;
			4'd2:    b = 9'd31;
			4'd3:    b = 9'd61;
			4'd4:    b = 9'd92;
			4'd5:    b = 9'd122;
			4'd6:    b = 9'd153;
			4'd7:    b = 9'd184;
			4'd8:    b = 9'd214;
			4'd9:    b = 9'd245;
			4'd10:   b = 9'd275;
			4'd11:   b = 9'd306;
			4'd12:   b = 9'd337;
			default: b = 9'd0;
		endcase
		return b;
	endfunction

endpackage

>>> sv/es2u_date.sv
// ----------------------------------------------------------------------------
// es2u_date: day count to Gregorian date and weekday
// Seven register stages, March-based year estimate with leap correction.
// ----------------------------------------------------------------------------
module es2u_date (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [15:0]      days,
	output es2u_pkg::date_t  date
);
	import es2u_pkg::*;

	logic valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	// stage 2
	logic [19:0] dm_c;
	logic [28:0] n_c;
	logic [15:0] wn_c;
	logic [19:0] dm_s2;
	logic [28:0] n_s2;
	logic [15:0] wn_s2;

	// stage 3
	logic [58:0] yprod_s3;
	logic [31:0] wprod_s3;
	logic [19:0] dm_s3;
	logic [15:0] wn_s3;

	// stage 4
	logic [11:0] yest_c;
	logic [12:0] wq_c;
	logic [2:0]  wday4_c;
	logic [11:0] year_s4;
	logic [2:0]  wday_s4;
	logic [19:0] dm_s4;
	logic [23:0] cprod_s4;

	// stage 5
	logic [4:0]  cent_c;
	logic [19:0] before_c;
	logic        leap_c;
	logic [10:0] yraw_s5;
	logic        leap_s5;
	logic [11:0] year_s5;
	logic [2:0]  wday_s5;

	// stage 6
	logic [8:0]  yday_c;
	logic [11:0] year6_c;
	logic [8:0]  yday_s6;
	logic [11:0] year_s6;
	logic [2:0]  wday_s6;

	// stage 7
	logic [11:0] mn_c;
	logic [24:0] mprod_s7;
	logic [8:0]  yday_s7;
	logic [11:0] year_s7;
	logic [2:0]  wday_s7;

	// stage 8
	logic [3:0]  mi_c;
	date_t       date_c;
	date_t       date_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_comb begin
		dm_c = 20'(days) + DAYS_TO_MAR0;
		n_c  = (29'(dm_c) + 29'(YEAR_OFFSET)) * 29'd400;
		wn_c = days + 16'd4;
	end

	always_comb begin
		yest_c  = yprod_s3[58:47];
		wq_c    = wprod_s3[31:19];
		wday4_c = 3'(wn_s3 - 16'(wq_c) * 16'd7);
	end

	// year / 100 from the reciprocal; year / 400 is that over four
	always_comb begin
		cent_c   = cprod_s4[23:19];
		before_c = 20'(year_s4) * 20'd365 + 20'(year_s4[11:2])
			- 20'(cent_c) + 20'(cent_c[4:2]);
		leap_c   = (year_s4[1:0] == 2'b00)
			&& ((year_s4 != 12'(cent_c) * 12'd100) || (cent_c[1:0] == 2'b00));
	end

	// negative day of year: estimate was a year ahead
	always_comb begin
		if (yraw_s5[10]) begin
			yday_c  = 9'(yraw_s5 + 11'd365 + 11'(leap_s5));
			year6_c = year_s5 - 12'd1;
		end else begin
			yday_c  = yraw_s5[8:0];
			year6_c = year_s5;
		end
	end

	always_comb mn_c = (12'(yday_s6) + 12'd31) * 12'd10;

	// Jan and Feb are months 11 and 12 of the March-based year
	always_comb begin
		mi_c        = mprod_s7[24:21];
		date_c.mday = 5'(yday_s7 - month_base(mi_c) + 9'd1);
		date_c.wday = wday_s7;
		if (yday_s7 >= 9'(MAR_BASE_DAY)) begin
			date_c.month = mi_c - 4'd10;
			date_c.year  = year_s7 + 12'd1;
		end else begin
			date_c.month = mi_c + 4'd2;
			date_c.year  = year_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			dm_s2 <= dm_c;
			n_s2  <= n_c;
			wn_s2 <= wn_c;
		end
		if (valid_s2) begin
			yprod_s3 <= 59'(n_s2) * 59'(YEAR_RECIP);
			wprod_s3 <= 32'(wn_s2) * 32'(WDAY_RECIP);
			dm_s3    <= dm_s2;
			wn_s3    <= wn_s2;
		end
		if (valid_s3) begin
			year_s4  <= yest_c;
			wday_s4  <= wday4_c;
			dm_s4    <= dm_s3;
			cprod_s4 <= 24'(yest_c) * 24'(CENT_RECIP);
		end
		if (valid_s4) begin
			yraw_s5 <= 11'(dm_s4 - before_c);
			leap_s5 <= leap_c;
			year_s5 <= year_s4;
			wday_s5 <= wday_s4;
		end
		if (valid_s5) begin
			yday_s6 <= yday_c;
			year_s6 <= year6_c;
			wday_s6 <= wday_s5;
		end
		if (valid_s6) begin
			mprod_s7 <= 25'(mn_c) * 25'(MON_RECIP);
			yday_s7  <= yday_s6;
			year_s7  <= year_s6;
			wday_s7  <= wday_s6;
		end
		if (valid_s7) begin
			date_s8 <= date_c;
		end
	end

	assign date = date_s8;

endmodule

>>> sv/epoch_seconds_to_utc_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar_core: Unix seconds to broken-down UTC time
// Eight-stage pipeline: day split, time of day, Gregorian date, weekday.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   ----------------------------------------------
//  request   start / busy       epoch_seconds[31:0]
//  result    done (1-cycle)     second, minute, hour, day_of_month, month,
//                               year, weekday
//
// One request per cycle; every request gives its result from the last
// stage registers (done high for one cycle). The stages hold the
// constant-reciprocal multiplier chain: secs/86400, then days to year,
// year/100 and the month lookup.
// busy stays low: the pipeline never stalls and results cannot be held off.
// arst_n clears the stage valid bits only; data registers carry no reset.
//
module epoch_seconds_to_utc_calendar_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month,
	output logic [11:0] year,
	output logic [2:0]  weekday
);
	import es2u_pkg::*;

	logic accept;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic valid_s5, valid_s6, valid_s7, valid_s8;

	// s1: day quotient product
	logic [31:0] secs_s1;
	logic [50:0] dprod_s1;
	logic [15:0] days_c;

	// s2..s8: time of day
	logic [16:0] rem_s2;
	logic [33:0] hprod_s3;
	logic [16:0] rem_s3;
	logic [4:0]  hour_c;
	logic [4:0]  hour_s4;
	logic [11:0] r2_s4;
	logic [23:0] minprod_s5;
	logic [4:0]  hour_s5;
	logic [11:0] r2_s5;
	logic [5:0]  minute_c;
	logic [5:0]  minute_s6, minute_s7, minute_s8;
	logic [5:0]  second_s6, second_s7, second_s8;
	logic [4:0]  hour_s6, hour_s7, hour_s8;

	date_t date;

	// Fully pipelined: a request is taken every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// days = (secs >> 7) * ceil(2^35 / 675) >> 35, exact over 25 bits
	assign days_c = dprod_s1[50:35];

	// hour = rem * ceil(2^29 / 3600) >> 29
	assign hour_c = hprod_s3[33:29];

	// minute = r2 * ceil(2^18 / 60) >> 18
	assign minute_c = minprod_s5[23:18];

	always_ff @(posedge clk) begin
		if (accept) begin
			secs_s1  <= epoch_seconds;
			dprod_s1 <= 51'(epoch_seconds[31:DAY_PRESHIFT]) * 51'(DAY_RECIP);
		end
		if (valid_s1) begin
			rem_s2 <= 17'(secs_s1 - 32'(days_c) * 32'(SECS_PER_DAY));
		end
		if (valid_s2) begin
			hprod_s3 <= 34'(rem_s2) * 34'(HOUR_RECIP);
			rem_s3   <= rem_s2;
		end
		if (valid_s3) begin
			hour_s4 <= hour_c;
			r2_s4   <= 12'(rem_s3 - 17'(hour_c) * 17'(SECS_PER_HOUR));
		end
		if (valid_s4) begin
			minprod_s5 <= 24'(r2_s4) * 24'(MIN_RECIP);
			hour_s5    <= hour_s4;
			r2_s5      <= r2_s4;
		end
		if (valid_s5) begin
			minute_s6 <= minute_c;
			second_s6 <= 6'(r2_s5 - 12'(minute_c) * 12'(SECS_PER_MIN));
			hour_s6   <= hour_s5;
		end
		if (valid_s6) begin
			minute_s7 <= minute_s6;
			second_s7 <= second_s6;
			hour_s7   <= hour_s6;
		end
		if (valid_s7) begin
			minute_s8 <= minute_s7;
			second_s8 <= second_s7;
			hour_s8   <= hour_s7;
		end
	end

	// Date and weekday path, stages 2..8
	es2u_date u_date (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.days     (days_c),
		.date     (date)
	);

	assign done         = valid_s8;
	assign second       = second_s8;
	assign minute       = minute_s8;
	assign hour         = hour_s8;
	assign day_of_month = date.mday;
	assign month        = date.month;
	assign year         = date.year;
	assign weekday      = date.wday;

endmodule

>>> sv/es2u_checker.sv
// ----------------------------------------------------------------------------
// es2u_checker: port-level checks for the epoch-to-UTC converter
// Fixed latency, result ranges and the epoch origin.
// ----------------------------------------------------------------------------
module es2u_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] epoch_seconds,
	input logic        done,
	input logic [5:0]  second,
	input logic [5:0]  minute,
	input logic [4:0]  hour,
	input logic [4:0]  day_of_month,
	input logic [3:0]  month,
	input logic [11:0] year,
	input logic [2:0]  weekday
);
	import es2u_pkg::*;

	// every accepted request is answered after the pipeline latency
	a_req_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("request not answered after pipeline latency");

	// no result without a request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching request");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (second < 6'd60 && minute < 6'd60 && hour < 5'd24
			&& day_of_month != 5'd0 && month != 4'd0 && month <= 4'd12
			&& weekday < 3'd7 && year >= 12'd1970 && year <= 12'd2106))
		else $error("result field out of range");

	// the epoch itself is Thursday 1970-01-01 00:00:00
	a_epoch_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && epoch_seconds == 32'd0) |-> ##LATENCY
			(year == 12'd1970 && month == 4'd1 && day_of_month == 5'd1
			&& weekday == 3'd4 && hour == 5'd0 && minute == 6'd0
			&& second == 6'd0))
		else $error("epoch origin converted wrongly");

endmodule

bind epoch_seconds_to_utc_calendar_core es2u_checker u_es2u_checker (.*);
